// ----- rtl/slt_pkg.sv -----
// Shared types and constants of the shared/exclusive lock table.
package slt_pkg;

  localparam int unsigned MODE_W  = 4;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned COUNT_W = 8;

  localparam int unsigned FLAG_WRITING   = 2;
  localparam int unsigned FLAG_APPENDING = 1;
  localparam int unsigned FLAG_UPDATING  = 0;
  localparam int unsigned FLAG_W         = 3;

  typedef enum logic [MODE_W-1:0] {
    OP_LOCK_SH     = 4'd0,
    OP_LOCK_EXCL   = 4'd1,
    OP_LOCK_HDR    = 4'd2,
    OP_UNLOCK_SH   = 4'd3,
    OP_UNLOCK_EXCL = 4'd4,
    OP_UNLOCK_HDR  = 4'd5,
    OP_EXCL_TO_SH  = 4'd6,
    OP_SH_TO_EXCL  = 4'd7,
    OP_START_APP   = 4'd8,
    OP_STOP_APP    = 4'd9,
    OP_STATUS      = 4'd10
  } mode_t;

  typedef struct packed {
    logic               in_range;
    mode_t              mode;
    logic [INDEX_W-1:0] idx;
  } item_t;

endpackage

// ----- rtl/slt_if.sv -----
// Request and response channel interfaces of the lock table.
interface slt_req_if;
  logic       valid;
  logic       ready;
  logic [3:0] mode;
  logic [9:0] lock_index;

  modport source (output valid, output mode, output lock_index, input ready);
  modport sink (input valid, input mode, input lock_index, output ready);
endinterface

interface slt_rsp_if;
  logic       valid;
  logic       ready;
  logic       granted;
  logic       error;
  logic [7:0] reader_count;
  logic       writing_now;
  logic       appending_now;
  logic       updating_now;

  modport source (output valid, output granted, output error, output reader_count,
                  output writing_now, output appending_now, output updating_now,
                  input ready);
  modport sink (input valid, input granted, input error, input reader_count,
                input writing_now, input appending_now, input updating_now,
                output ready);
endinterface

// ----- rtl/shared_exclusive_lock_table.sv -----
// Top level of the shared/exclusive lock table.
// A table of NUM_LOCKS readers-writer locks; each request beat names a lock and an
// operation, and yields one response beat with the entry as it stands afterwards.
// After reset the table is cleared one entry per cycle, during which no request is
// taken. Each request then passes a fetch state that reads its entry from the RAM
// and an execute state that updates and writes it back, held while a response
// waits to be taken. A two-entry queue and a response register let requests be
// taken while a response waits.
module shared_exclusive_lock_table #(
  parameter int unsigned NUM_LOCKS   = 1024,
  parameter int unsigned MAX_READERS = 255
) (
  input  logic      clk,
  input  logic      rst,
  slt_req_if.sink   req,
  slt_rsp_if.source rsp
);
  import slt_pkg::*;

  item_t head;
  logic  head_valid;
  logic  pop;
  logic  clearing;

  slt_front #(
    .NUM_LOCKS(NUM_LOCKS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .clearing  (clearing),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop)
  );

  slt_back #(
    .NUM_LOCKS  (NUM_LOCKS),
    .MAX_READERS(MAX_READERS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .clearing  (clearing),
    .rsp       (rsp)
  );

endmodule

// ----- rtl/slt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module slt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/slt_front.sv -----
// Front end: accepts requests, classifies them and queues them for execution.
module slt_front #(
  parameter int unsigned NUM_LOCKS = 1024
) (
  input  logic          clk,
  input  logic          rst,
  slt_req_if.sink       req,
  input  logic          clearing,
  output slt_pkg::item_t head,
  output logic          head_valid,
  input  logic          pop
);
  import slt_pkg::*;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = 1;
  localparam logic [16:0] NUM_LOCKS_EXT = 17'(NUM_LOCKS);

  item_t            queue [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  item_t            incoming;
  logic             push;

  assign req.ready = (count != (PTR_W+1)'(QDEPTH)) && !clearing;
  assign push      = req.valid && req.ready;

  always_comb begin
    incoming.in_range = {7'd0, req.lock_index} < NUM_LOCKS_EXT;
    incoming.mode     = mode_t'(req.mode);
    incoming.idx      = req.lock_index;
  end

  assign head       = queue[rd_ptr];
  assign head_valid = count != '0;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

// ----- rtl/slt_back.sv -----
// Back end: clears the table, then executes queued requests as read-modify-writes.
module slt_back #(
  parameter int unsigned NUM_LOCKS   = 1024,
  parameter int unsigned MAX_READERS = 255
) (
  input  logic           clk,
  input  logic           rst,
  input  slt_pkg::item_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           clearing,
  slt_rsp_if.source      rsp
);
  import slt_pkg::*;

  localparam int unsigned AW = NUM_LOCKS > 1 ? $clog2(NUM_LOCKS) : 1;
  localparam int unsigned RW = $clog2(MAX_READERS + 1);
  localparam int unsigned EW = RW + FLAG_W;
  localparam logic [RW-1:0] MAX_R = RW'(MAX_READERS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_LOCKS - 1);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_FETCH = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [AW-1:0]     clr_addr;
  item_t             item;
  logic [AW+INDEX_W-1:0] addr_ext;
  logic [AW-1:0]     item_addr;
  logic [AW+INDEX_W-1:0] head_ext;
  logic [AW-1:0]     head_addr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [EW-1:0]     wdata;
  logic              re;
  logic [EW-1:0]     rdata;
  logic              fire;

  logic [RW-1:0] r;
  logic          w;
  logic          a;
  logic          u;
  logic [RW-1:0] nr;
  logic          nw;
  logic          na;
  logic          nu;
  logic          g;
  logic          err;
  logic          may_share;
  logic [RW+COUNT_W-1:0] nr_ext;

  assign head_ext  = {AW'(0), head.idx};
  assign head_addr = head_ext[AW-1:0];
  assign addr_ext  = {AW'(0), item.idx};
  assign item_addr = addr_ext[AW-1:0];

  assign clearing = state == S_CLEAR;
  assign pop      = (state == S_FETCH) && head_valid;
  assign re       = pop;
  assign fire     = (state == S_EXEC) && (!rsp.valid || rsp.ready);

  slt_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_LOCKS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(head_addr),
    .rdata(rdata)
  );

  always_comb begin
    r  = rdata[EW-1:FLAG_W];
    w  = rdata[FLAG_WRITING];
    a  = rdata[FLAG_APPENDING];
    u  = rdata[FLAG_UPDATING];
    nr = r;
    nw = w;
    na = a;
    nu = u;
    g   = 1'b0;
    err = 1'b0;
    may_share = (!w || a) && (r < MAX_R);
    unique case (item.mode)
      OP_LOCK_SH: begin
        if (may_share) begin
          nr = r + 1'b1;
          g  = 1'b1;
        end
      end
      OP_LOCK_EXCL: begin
        if (!w && r == '0) begin
          nw = 1'b1;
          g  = 1'b1;
        end
      end
      OP_LOCK_HDR: begin
        if (may_share && !u) begin
          nr = r + 1'b1;
          nu = 1'b1;
          g  = 1'b1;
        end
      end
      OP_UNLOCK_SH: begin
        if (r != '0) begin
          nr = r - 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      OP_UNLOCK_EXCL: begin
        if (w) begin
          nw = 1'b0;
          na = 1'b0;
        end else begin
          err = 1'b1;
        end
      end
      OP_UNLOCK_HDR: begin
        if (u && r != '0) begin
          nu = 1'b0;
          nr = r - 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      OP_EXCL_TO_SH: begin
        if (w && r < MAX_R) begin
          nr = r + 1'b1;
          nw = 1'b0;
          na = 1'b0;
          g  = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      OP_SH_TO_EXCL: begin
        if (r != '0) begin
          nr = r - 1'b1;
          if (!w && r == RW'(1)) begin
            nw = 1'b1;
            g  = 1'b1;
          end
        end else begin
          err = 1'b1;
        end
      end
      OP_START_APP: begin
        if (w) begin
          na = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      OP_STOP_APP: begin
        if (w && a) begin
          na = 1'b0;
          g  = r == '0;
        end else begin
          err = 1'b1;
        end
      end
      OP_STATUS: begin
      end
      default: begin
        err = 1'b1;
      end
    endcase
    if (!item.in_range) begin
      nr  = '0;
      nw  = 1'b0;
      na  = 1'b0;
      nu  = 1'b0;
      g   = 1'b0;
      err = 1'b1;
    end
    nr_ext = {COUNT_W'(0), nr};
  end

  always_comb begin
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = fire && item.in_range;
      waddr = item_addr;
      wdata = {nr, nw, na, nu};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (head_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_next = S_FETCH;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (fire) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item <= head;
    end
    if (fire) begin
      rsp.granted       <= g;
      rsp.error         <= err;
      rsp.reader_count  <= nr_ext[COUNT_W-1:0];
      rsp.writing_now   <= nw;
      rsp.appending_now <= na;
      rsp.updating_now  <= nu;
    end
  end

  a_no_write_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && we) |-> item.in_range)
    else $error("Table written for an out-of-range request.");

  a_clear_once: assert property (@(posedge clk) disable iff (rst)
    (state != S_CLEAR) |=> (state != S_CLEAR))
    else $error("Clearing pass restarted outside reset.");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> (head_valid && state == S_FETCH))
    else $error("Queue popped while empty or outside fetch.");

  a_fire_after_fetch: assert property (@(posedge clk) disable iff (rst)
    fire |-> ($past(state) == S_FETCH || $past(state) == S_EXEC))
    else $error("Execution without a preceding fetch.");

endmodule
